// ===== rtl/pfr_pkg.sv =====
// shared types, constants and helpers for the planar frame rotation block
package pfr_pkg;

    localparam int DATA_WIDTH = 32;
    localparam int WIDE       = 64;
    localparam int NORM_W     = 31;
    localparam int LEN_W      = 32;
    localparam int COEF_W     = 32;
    localparam int COEF_FRAC  = 30;
    localparam int FIFO_DEPTH = 4;

    typedef enum logic [1:0] {
        CMD_VEC_TO_ELEM   = 2'd0,
        CMD_VEC_TO_GLOBAL = 2'd1,
        CMD_BLK_TO_ELEM   = 2'd2,
        CMD_BLK_TO_GLOBAL = 2'd3
    } cmd_t;

    typedef logic signed [DATA_WIDTH-1:0] data_t;
    typedef logic signed [WIDE-1:0]       wide_t;
    typedef logic signed [COEF_W-1:0]     coef_t;
    typedef logic [WIDE-1:0]              mag_t;
    typedef logic [NORM_W-1:0]            norm_t;

    typedef struct packed {
        cmd_t  cmd;
        data_t node0_x;
        data_t node0_y;
        data_t node1_x;
        data_t node1_y;
        data_t blk_00;
        data_t blk_01;
        data_t blk_10;
        data_t blk_11;
    } in_t;

    typedef struct packed {
        data_t out_00;
        data_t out_01;
        data_t out_10;
        data_t out_11;
        logic  degenerate;
    } out_t;

    typedef struct packed {
        cmd_t  cmd;
        logic  sx;
        logic  sy;
        logic  degen;
        mag_t  ux;
        mag_t  uy;
        data_t b00;
        data_t b01;
        data_t b10;
        data_t b11;
    } front_t;

    typedef struct packed {
        cmd_t  cmd;
        logic  sx;
        logic  sy;
        logic  degen;
        norm_t nx;
        norm_t ny;
        data_t b00;
        data_t b01;
        data_t b10;
        data_t b11;
    } job_t;

    typedef struct packed {
        cmd_t  cmd;
        logic  degen;
        coef_t p00;
        coef_t p01;
        coef_t p10;
        coef_t p11;
    } rot_side_t;

    typedef struct packed {
        cmd_t  cmd;
        logic  degen;
        wide_t t00;
        wide_t t10;
    } vec_side_t;

    function automatic logic is_block(cmd_t c);
        return (c == CMD_BLK_TO_ELEM) || (c == CMD_BLK_TO_GLOBAL);
    endfunction

    function automatic logic is_to_elem(cmd_t c);
        return (c == CMD_VEC_TO_ELEM) || (c == CMD_BLK_TO_ELEM);
    endfunction

endpackage

// ===== rtl/pfr_front.sv =====
// front end: accepts items, forms node differences and normalizes them
module pfr_front (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           item_valid,
    output logic           item_ready,
    input  pfr_pkg::in_t   item,
    output logic           push,
    input  logic           full,
    output pfr_pkg::job_t  push_job
);

    logic v1_reg, v2_reg, v3_reg;
    pfr_pkg::front_t f1_reg, f2_reg, f3_reg;
    pfr_pkg::front_t f1_next;
    logic en;

    // shift both magnitudes together until the top byte of the larger is nonzero
    function automatic pfr_pkg::front_t norm_coarse(pfr_pkg::front_t f);
        pfr_pkg::front_t r;
        pfr_pkg::mag_t o;
        r = f;
        o = r.ux | r.uy;
        if (o[pfr_pkg::WIDE-1 -: 32] == '0)
        begin
            r.ux = r.ux << 32; r.uy = r.uy << 32; o = o << 32;
        end
        if (o[pfr_pkg::WIDE-1 -: 16] == '0)
        begin
            r.ux = r.ux << 16; r.uy = r.uy << 16; o = o << 16;
        end
        if (o[pfr_pkg::WIDE-1 -: 8] == '0)
        begin
            r.ux = r.ux << 8; r.uy = r.uy << 8;
        end
        return r;
    endfunction

    function automatic pfr_pkg::front_t norm_fine(pfr_pkg::front_t f);
        pfr_pkg::front_t r;
        pfr_pkg::mag_t o;
        r = f;
        o = r.ux | r.uy;
        if (o[pfr_pkg::WIDE-1 -: 4] == '0)
        begin
            r.ux = r.ux << 4; r.uy = r.uy << 4; o = o << 4;
        end
        if (o[pfr_pkg::WIDE-1 -: 2] == '0)
        begin
            r.ux = r.ux << 2; r.uy = r.uy << 2; o = o << 2;
        end
        if (o[pfr_pkg::WIDE-1] == 1'b0)
        begin
            r.ux = r.ux << 1; r.uy = r.uy << 1;
        end
        return r;
    endfunction

    assign en         = !v3_reg || !full;
    assign item_ready = en;
    assign push       = v3_reg && !full;

    always_comb
    begin
        logic signed [pfr_pkg::DATA_WIDTH:0] dx, dy;
        logic [pfr_pkg::DATA_WIDTH:0] ax, ay;
        dx = {item.node1_x[pfr_pkg::DATA_WIDTH-1], item.node1_x}
           - {item.node0_x[pfr_pkg::DATA_WIDTH-1], item.node0_x};
        dy = {item.node1_y[pfr_pkg::DATA_WIDTH-1], item.node1_y}
           - {item.node0_y[pfr_pkg::DATA_WIDTH-1], item.node0_y};
        ax = dx[pfr_pkg::DATA_WIDTH] ? ~dx + 1'b1 : dx;
        ay = dy[pfr_pkg::DATA_WIDTH] ? ~dy + 1'b1 : dy;
        f1_next.cmd   = item.cmd;
        f1_next.sx    = dx[pfr_pkg::DATA_WIDTH];
        f1_next.sy    = dy[pfr_pkg::DATA_WIDTH];
        f1_next.ux    = pfr_pkg::WIDE'(ax[pfr_pkg::DATA_WIDTH-1:0]);
        f1_next.uy    = pfr_pkg::WIDE'(ay[pfr_pkg::DATA_WIDTH-1:0]);
        f1_next.degen = (ax == '0) && (ay == '0);
        f1_next.b00   = item.blk_00;
        f1_next.b01   = item.blk_01;
        f1_next.b10   = item.blk_10;
        f1_next.b11   = item.blk_11;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= item_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            f1_reg <= f1_next;
            f2_reg <= norm_coarse(f1_reg);
            f3_reg <= norm_fine(f2_reg);
        end
    end

    // top bits of the larger normalized word sit in [2^30, 2^31) unless both are zero
    always_comb
    begin
        push_job.cmd   = f3_reg.cmd;
        push_job.sx    = f3_reg.sx;
        push_job.sy    = f3_reg.sy;
        push_job.degen = f3_reg.degen;
        push_job.nx    = f3_reg.ux[pfr_pkg::WIDE-1 -: pfr_pkg::NORM_W];
        push_job.ny    = f3_reg.uy[pfr_pkg::WIDE-1 -: pfr_pkg::NORM_W];
        push_job.b00   = f3_reg.b00;
        push_job.b01   = f3_reg.b01;
        push_job.b10   = f3_reg.b10;
        push_job.b11   = f3_reg.b11;
    end

endmodule

// ===== rtl/pfr_fifo.sv =====
// short queue of classified jobs between front end and back end
module pfr_fifo #(
    parameter int DEPTH = pfr_pkg::FIFO_DEPTH
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  pfr_pkg::job_t  push_job,
    output logic           full,
    input  logic           pop,
    output pfr_pkg::job_t  pop_job,
    output logic           empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    pfr_pkg::job_t mem [DEPTH];
    logic [AW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0] count_reg;
    logic do_push, do_pop;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign pop_job = mem[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= (wr_ptr_reg == AW'(DEPTH-1)) ? '0 : wr_ptr_reg + 1'b1;
            if (do_pop)
                rd_ptr_reg <= (rd_ptr_reg == AW'(DEPTH-1)) ? '0 : rd_ptr_reg + 1'b1;
            if (do_push && !do_pop)
                count_reg <= count_reg + 1'b1;
            else if (do_pop && !do_push)
                count_reg <= count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem[wr_ptr_reg] <= push_job;
    end

endmodule

// ===== rtl/pfr_coef.sv =====
// cos and sin pipeline: squares, bit-serial root, two restoring dividers
module pfr_coef (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            en,
    input  logic            job_valid,
    input  pfr_pkg::job_t   job,
    output logic            coef_valid,
    output pfr_pkg::coef_t  c,
    output pfr_pkg::coef_t  s,
    output pfr_pkg::job_t   coef_job
);

    localparam int LEN_W     = pfr_pkg::LEN_W;
    localparam int NORM_W    = pfr_pkg::NORM_W;
    localparam int SQ_STEPS  = LEN_W;
    localparam int RAD_W     = 2 * LEN_W;
    localparam int REM_W     = LEN_W + 1;
    localparam int TRY_W     = LEN_W + 3;
    localparam int SQ_W      = 2 * NORM_W;
    localparam int DIV_STEPS = NORM_W;
    localparam int NUM_W     = NORM_W + pfr_pkg::COEF_FRAC + 1;

    logic v0_reg, v1_reg;
    pfr_pkg::job_t j0_reg, j1_reg;
    logic [SQ_W-1:0] sqx_reg, sqy_reg;

    logic [SQ_STEPS:0]  sq_v_reg;
    pfr_pkg::job_t      sq_j_reg    [SQ_STEPS+1];
    logic [RAD_W-1:0]   sq_rad_reg  [SQ_STEPS+1];
    logic [REM_W-1:0]   sq_rem_reg  [SQ_STEPS+1];
    logic [LEN_W-1:0]   sq_root_reg [SQ_STEPS+1];
    logic [REM_W-1:0]   sq_rem_next [SQ_STEPS];
    logic [LEN_W-1:0]   sq_root_next[SQ_STEPS];

    logic [DIV_STEPS:0] dv_v_reg;
    pfr_pkg::job_t      dv_j_reg   [DIV_STEPS+1];
    logic [LEN_W-1:0]   dv_len_reg [DIV_STEPS+1];
    logic [LEN_W-1:0]   dv_remx_reg[DIV_STEPS+1];
    logic [LEN_W-1:0]   dv_remy_reg[DIV_STEPS+1];
    logic [NORM_W-1:0]  dv_lox_reg [DIV_STEPS+1];
    logic [NORM_W-1:0]  dv_loy_reg [DIV_STEPS+1];
    logic [NORM_W-1:0]  dv_qx_reg  [DIV_STEPS+1];
    logic [NORM_W-1:0]  dv_qy_reg  [DIV_STEPS+1];
    logic [LEN_W-1:0]   dv_remx_next[DIV_STEPS];
    logic [LEN_W-1:0]   dv_remy_next[DIV_STEPS];
    logic [NORM_W-1:0]  dv_qx_next [DIV_STEPS];
    logic [NORM_W-1:0]  dv_qy_next [DIV_STEPS];

    logic [NUM_W-1:0] numx, numy;
    logic fin_v_reg;
    pfr_pkg::job_t fin_j_reg;
    pfr_pkg::coef_t c_reg, s_reg;

    // one root bit per stage
    always_comb
    begin
        logic [TRY_W-1:0] sq_try, sq_trial;
        for (int k = 0; k < SQ_STEPS; k++)
        begin
            sq_try   = {sq_rem_reg[k], sq_rad_reg[k][RAD_W-1 -: 2]};
            sq_trial = {1'b0, sq_root_reg[k], 2'b01};
            if (sq_try >= sq_trial)
            begin
                sq_rem_next[k]  = REM_W'(sq_try - sq_trial);
                sq_root_next[k] = {sq_root_reg[k][LEN_W-2:0], 1'b1};
            end
            else
            begin
                sq_rem_next[k]  = REM_W'(sq_try);
                sq_root_next[k] = {sq_root_reg[k][LEN_W-2:0], 1'b0};
            end
        end
    end

    // rounded numerators: n * 2^30 + len / 2
    assign numx = (NUM_W'(sq_j_reg[SQ_STEPS].nx) << pfr_pkg::COEF_FRAC)
                + NUM_W'(sq_root_reg[SQ_STEPS] >> 1);
    assign numy = (NUM_W'(sq_j_reg[SQ_STEPS].ny) << pfr_pkg::COEF_FRAC)
                + NUM_W'(sq_root_reg[SQ_STEPS] >> 1);

    // one quotient bit per stage for each divider
    always_comb
    begin
        logic [LEN_W:0] rx, ry, dd;
        logic gx, gy;
        for (int k = 0; k < DIV_STEPS; k++)
        begin
            dd = {1'b0, dv_len_reg[k]};
            rx = {dv_remx_reg[k], dv_lox_reg[k][NORM_W-1]};
            ry = {dv_remy_reg[k], dv_loy_reg[k][NORM_W-1]};
            gx = (rx >= dd);
            gy = (ry >= dd);
            dv_remx_next[k] = gx ? LEN_W'(rx - dd) : LEN_W'(rx);
            dv_remy_next[k] = gy ? LEN_W'(ry - dd) : LEN_W'(ry);
            dv_qx_next[k]   = {dv_qx_reg[k][NORM_W-2:0], gx};
            dv_qy_next[k]   = {dv_qy_reg[k][NORM_W-2:0], gy};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg    <= 1'b0;
            v1_reg    <= 1'b0;
            sq_v_reg  <= '0;
            dv_v_reg  <= '0;
            fin_v_reg <= 1'b0;
        end
        else if (en)
        begin
            v0_reg    <= job_valid;
            v1_reg    <= v0_reg;
            sq_v_reg  <= {sq_v_reg[SQ_STEPS-1:0], v1_reg};
            dv_v_reg  <= {dv_v_reg[DIV_STEPS-1:0], sq_v_reg[SQ_STEPS]};
            fin_v_reg <= dv_v_reg[DIV_STEPS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            j0_reg  <= job;
            j1_reg  <= j0_reg;
            sqx_reg <= j0_reg.nx * j0_reg.nx;
            sqy_reg <= j0_reg.ny * j0_reg.ny;

            sq_j_reg[0]    <= j1_reg;
            sq_rad_reg[0]  <= RAD_W'(sqx_reg) + RAD_W'(sqy_reg);
            sq_rem_reg[0]  <= '0;
            sq_root_reg[0] <= '0;
            for (int k = 0; k < SQ_STEPS; k++)
            begin
                sq_j_reg[k+1]    <= sq_j_reg[k];
                sq_rad_reg[k+1]  <= sq_rad_reg[k] << 2;
                sq_rem_reg[k+1]  <= sq_rem_next[k];
                sq_root_reg[k+1] <= sq_root_next[k];
            end

            dv_j_reg[0]    <= sq_j_reg[SQ_STEPS];
            dv_len_reg[0]  <= sq_root_reg[SQ_STEPS];
            dv_remx_reg[0] <= LEN_W'(numx[NUM_W-1:NORM_W]);
            dv_remy_reg[0] <= LEN_W'(numy[NUM_W-1:NORM_W]);
            dv_lox_reg[0]  <= numx[NORM_W-1:0];
            dv_loy_reg[0]  <= numy[NORM_W-1:0];
            dv_qx_reg[0]   <= '0;
            dv_qy_reg[0]   <= '0;
            for (int k = 0; k < DIV_STEPS; k++)
            begin
                dv_j_reg[k+1]    <= dv_j_reg[k];
                dv_len_reg[k+1]  <= dv_len_reg[k];
                dv_remx_reg[k+1] <= dv_remx_next[k];
                dv_remy_reg[k+1] <= dv_remy_next[k];
                dv_lox_reg[k+1]  <= dv_lox_reg[k] << 1;
                dv_loy_reg[k+1]  <= dv_loy_reg[k] << 1;
                dv_qx_reg[k+1]   <= dv_qx_next[k];
                dv_qy_reg[k+1]   <= dv_qy_next[k];
            end

            fin_j_reg <= dv_j_reg[DIV_STEPS];
            c_reg <= dv_j_reg[DIV_STEPS].sx ? -pfr_pkg::coef_t'({1'b0, dv_qx_reg[DIV_STEPS]})
                                            :  pfr_pkg::coef_t'({1'b0, dv_qx_reg[DIV_STEPS]});
            s_reg <= dv_j_reg[DIV_STEPS].sy ? -pfr_pkg::coef_t'({1'b0, dv_qy_reg[DIV_STEPS]})
                                            :  pfr_pkg::coef_t'({1'b0, dv_qy_reg[DIV_STEPS]});
        end
    end

    assign coef_valid = fin_v_reg;
    assign coef_job   = fin_j_reg;
    assign c          = c_reg;
    assign s          = s_reg;

endmodule

// ===== rtl/pfr_dot2.sv =====
// pipelined x0*c0 + x1*c1 with Q1.30 round half up and 64-bit saturation
module pfr_dot2 (
    input  logic            clk,
    input  logic            en,
    input  pfr_pkg::wide_t  x0,
    input  pfr_pkg::wide_t  x1,
    input  pfr_pkg::coef_t  c0,
    input  pfr_pkg::coef_t  c1,
    output pfr_pkg::wide_t  y
);

    localparam int HALF_W = pfr_pkg::WIDE / 2;
    localparam int LO_P_W = HALF_W + 1 + pfr_pkg::COEF_W;
    localparam int HI_P_W = HALF_W + pfr_pkg::COEF_W;
    localparam int PW     = pfr_pkg::WIDE + pfr_pkg::COEF_W + 2;
    localparam int TOP    = pfr_pkg::COEF_FRAC + pfr_pkg::WIDE - 1;
    localparam logic signed [PW-1:0] RND_HALF = PW'(1) <<< (pfr_pkg::COEF_FRAC - 1);

    logic signed [LO_P_W-1:0] pl0_reg, pl1_reg;
    logic signed [HI_P_W-1:0] ph0_reg, ph1_reg;
    logic signed [PW-1:0]     p0_reg, p1_reg, sum_reg;
    logic [PW-1:TOP]          top_bits;
    pfr_pkg::wide_t           y_reg;

    assign top_bits = sum_reg[PW-1:TOP];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            // split the 64-bit operand into a signed upper and unsigned lower half
            pl0_reg <= $signed({1'b0, x0[HALF_W-1:0]}) * c0;
            ph0_reg <= $signed(x0[pfr_pkg::WIDE-1:HALF_W]) * c0;
            pl1_reg <= $signed({1'b0, x1[HALF_W-1:0]}) * c1;
            ph1_reg <= $signed(x1[pfr_pkg::WIDE-1:HALF_W]) * c1;

            p0_reg  <= (PW'(ph0_reg) <<< HALF_W) + PW'(pl0_reg);
            p1_reg  <= (PW'(ph1_reg) <<< HALF_W) + PW'(pl1_reg);

            sum_reg <= p0_reg + p1_reg + RND_HALF;

            if ((&top_bits) || !(|top_bits))
                y_reg <= sum_reg[TOP:pfr_pkg::COEF_FRAC];
            else if (sum_reg[PW-1])
                y_reg <= {1'b1, {(pfr_pkg::WIDE-1){1'b0}}};
            else
                y_reg <= {1'b0, {(pfr_pkg::WIDE-1){1'b1}}};
        end
    end

    assign y = y_reg;

endmodule

// ===== rtl/pfr_rotate.sv =====
// rotation back end: P*M (or P*v), then T*P^T, then output register
module pfr_rotate (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            en,
    input  logic            coef_valid,
    input  pfr_pkg::coef_t  c,
    input  pfr_pkg::coef_t  s,
    input  pfr_pkg::job_t   coef_job,
    output logic            result_valid,
    output pfr_pkg::out_t   result
);

    localparam int DOT_LAT = 4;

    pfr_pkg::coef_t p_in [2][2];
    pfr_pkg::coef_t pb   [2][2];
    pfr_pkg::data_t blk  [2][2];
    pfr_pkg::wide_t t_a  [2][2];
    pfr_pkg::wide_t t_b  [2][2];
    logic vec;

    logic [DOT_LAT-1:0]  sa_v_reg, sb_v_reg;
    pfr_pkg::rot_side_t  sa_reg [DOT_LAT];
    pfr_pkg::vec_side_t  sb_reg [DOT_LAT];
    pfr_pkg::rot_side_t  sa_in, sa_end;
    pfr_pkg::vec_side_t  sb_end;
    logic                result_valid_reg;
    pfr_pkg::out_t       result_reg, result_next;

    function automatic pfr_pkg::data_t sat_data(pfr_pkg::wide_t v);
        logic [pfr_pkg::WIDE-1:pfr_pkg::DATA_WIDTH-1] hi;
        hi = v[pfr_pkg::WIDE-1:pfr_pkg::DATA_WIDTH-1];
        if ((&hi) || !(|hi))
            return v[pfr_pkg::DATA_WIDTH-1:0];
        else if (v[pfr_pkg::WIDE-1])
            return {1'b1, {(pfr_pkg::DATA_WIDTH-1){1'b0}}};
        else
            return {1'b0, {(pfr_pkg::DATA_WIDTH-1){1'b1}}};
    endfunction

    always_comb
    begin
        p_in[0][0] = c;
        p_in[1][1] = c;
        if (pfr_pkg::is_to_elem(coef_job.cmd))
        begin
            p_in[0][1] = s;
            p_in[1][0] = -s;
        end
        else
        begin
            p_in[0][1] = -s;
            p_in[1][0] = s;
        end
        blk[0][0] = coef_job.b00;
        blk[0][1] = coef_job.b01;
        blk[1][0] = coef_job.b10;
        blk[1][1] = coef_job.b11;
        vec = !pfr_pkg::is_block(coef_job.cmd);

        sa_in.cmd   = coef_job.cmd;
        sa_in.degen = coef_job.degen;
        sa_in.p00   = p_in[0][0];
        sa_in.p01   = p_in[0][1];
        sa_in.p10   = p_in[1][0];
        sa_in.p11   = p_in[1][1];

        sa_end = sa_reg[DOT_LAT-1];
        sb_end = sb_reg[DOT_LAT-1];
        pb[0][0] = sa_end.p00;
        pb[0][1] = sa_end.p01;
        pb[1][0] = sa_end.p10;
        pb[1][1] = sa_end.p11;
    end

    for (genvar i = 0; i < 2; i++)
    begin : g_row
        for (genvar j = 0; j < 2; j++)
        begin : g_col
            pfr_pkg::wide_t xa0, xa1;
            // vectors use column 0 units with v0, v1 as operands
            assign xa0 = pfr_pkg::WIDE'(blk[0][j]);
            assign xa1 = (j == 0 && vec) ? pfr_pkg::WIDE'(blk[0][1])
                                         : pfr_pkg::WIDE'(blk[1][j]);

            pfr_dot2 u_first (
                .clk (clk),
                .en  (en),
                .x0  (xa0),
                .x1  (xa1),
                .c0  (p_in[i][0]),
                .c1  (p_in[i][1]),
                .y   (t_a[i][j])
            );

            pfr_dot2 u_second (
                .clk (clk),
                .en  (en),
                .x0  (t_a[i][0]),
                .x1  (t_a[i][1]),
                .c0  (pb[j][0]),
                .c1  (pb[j][1]),
                .y   (t_b[i][j])
            );
        end
    end

    always_comb
    begin
        result_next = '0;
        if (sb_end.degen)
            result_next.degenerate = 1'b1;
        else if (pfr_pkg::is_block(sb_end.cmd))
        begin
            result_next.out_00 = sat_data(t_b[0][0]);
            result_next.out_01 = sat_data(t_b[0][1]);
            result_next.out_10 = sat_data(t_b[1][0]);
            result_next.out_11 = sat_data(t_b[1][1]);
        end
        else
        begin
            result_next.out_00 = sat_data(sb_end.t00);
            result_next.out_01 = sat_data(sb_end.t10);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sa_v_reg         <= '0;
            sb_v_reg         <= '0;
            result_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            sa_v_reg         <= {sa_v_reg[DOT_LAT-2:0], coef_valid};
            sb_v_reg         <= {sb_v_reg[DOT_LAT-2:0], sa_v_reg[DOT_LAT-1]};
            result_valid_reg <= sb_v_reg[DOT_LAT-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sa_reg[0]        <= sa_in;
            sb_reg[0].cmd    <= sa_end.cmd;
            sb_reg[0].degen  <= sa_end.degen;
            sb_reg[0].t00    <= t_a[0][0];
            sb_reg[0].t10    <= t_a[1][0];
            for (int k = 1; k < DOT_LAT; k++)
            begin
                sa_reg[k] <= sa_reg[k-1];
                sb_reg[k] <= sb_reg[k-1];
            end
            result_reg <= result_next;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

// ===== rtl/planar_frame_rotation.sv =====
// top level: rotation of 2d vectors and 2x2 blocks between global and element frames
//
//  channel   signals                                   beat
//  item      item_valid, item_ready, item (in_t)       nodes, command, vector or block
//  result    result_valid, result_ready, result (out_t) rotated values, degenerate flag
//
// one beat accepted per cycle while the queue has room; the longest parts of the path are the
// one-bit-per-stage square root (32 stages) and the two dividers (31 stages)
// reset clears all valid flags and the queue pointers; payload is not reset
// the front end keeps accepting while the back end stalls until the queue fills
// the back end stalls as a whole only when a result waits and result_ready is low
module planar_frame_rotation #(
    parameter int FIFO_DEPTH = pfr_pkg::FIFO_DEPTH
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           item_valid,
    output logic           item_ready,
    input  pfr_pkg::in_t   item,
    output logic           result_valid,
    input  logic           result_ready,
    output pfr_pkg::out_t  result
);

    logic push, full, pop, empty, back_en;
    pfr_pkg::job_t push_job, pop_job, coef_job;
    logic coef_valid;
    pfr_pkg::coef_t c, s;

    assign back_en = !result_valid || result_ready;
    assign pop     = back_en && !empty;

    pfr_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item),
        .push       (push),
        .full       (full),
        .push_job   (push_job)
    );

    pfr_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .full     (full),
        .pop      (pop),
        .pop_job  (pop_job),
        .empty    (empty)
    );

    pfr_coef u_coef (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (back_en),
        .job_valid  (pop),
        .job        (pop_job),
        .coef_valid (coef_valid),
        .c          (c),
        .s          (s),
        .coef_job   (coef_job)
    );

    pfr_rotate u_rotate (
        .clk          (clk),
        .rst_n        (rst_n),
        .en           (back_en),
        .coef_valid   (coef_valid),
        .c            (c),
        .s            (s),
        .coef_job     (coef_job),
        .result_valid (result_valid),
        .result       (result)
    );

endmodule

// ===== sim/planar_frame_rotation_tb.sv =====
// self-checking testbench for the planar frame rotation block
`timescale 1ns / 100ps

module planar_frame_rotation_tb;

    localparam int N_RANDOM = 500;
    localparam int MAX_ERR_SHOWN = 10;
    localparam logic signed [31:0] DMAX = 32'sh7fff_ffff;
    localparam logic signed [31:0] DMIN = 32'sh8000_0000;

    logic           clk;
    logic           rst_n;
    logic           item_valid;
    logic           item_ready;
    pfr_pkg::in_t   item;
    logic           result_valid;
    logic           result_ready;
    pfr_pkg::out_t  result;

    pfr_pkg::out_t  expected_q[$];
    int    n_mismatch;
    int    n_results;
    int    n_degen;
    int    n_sat;
    int    cmd_seen[4];
    bit    stim_done;
    bit    hold_off;

    planar_frame_rotation DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #20ms;
        $display("timeout waiting for results");
        $display("*** FAILED ***");
        $finish;
    end

    // round half up of a 128-bit sum, then clamp to the given width
    function automatic logic signed [63:0] round_sat(logic signed [127:0] acc, int bits);
        logic signed [127:0] r;
        logic signed [127:0] hi;
        logic signed [127:0] lo;
        r  = (acc + (128'sd1 <<< 29)) >>> 30;
        hi = (128'sd1 <<< (bits - 1)) - 128'sd1;
        lo = -(128'sd1 <<< (bits - 1));
        if (r > hi)
            return hi[63:0];
        if (r < lo)
            return lo[63:0];
        return r[63:0];
    endfunction

    function automatic logic signed [127:0] mac2(logic signed [63:0] a, logic signed [63:0] ca,
                                                 logic signed [63:0] b, logic signed [63:0] cb);
        logic signed [127:0] pa;
        logic signed [127:0] pb;
        pa = 128'(a) * 128'(ca);
        pb = 128'(b) * 128'(cb);
        return pa + pb;
    endfunction

    function automatic logic [63:0] int_sqrt(logic [63:0] n);
        logic [63:0] res;
        logic [63:0] bitv;
        res  = 64'd0;
        bitv = 64'd1 << 62;
        while (bitv > n)
            bitv >>= 2;
        while (bitv != 0)
        begin
            if (n >= res + bitv)
            begin
                n   = n - (res + bitv);
                res = (res >> 1) + bitv;
            end
            else
                res = res >> 1;
            bitv >>= 2;
        end
        return res;
    endfunction

    function automatic pfr_pkg::out_t rotate_item(pfr_pkg::in_t it);
        pfr_pkg::out_t o;
        logic signed [63:0] dx;
        logic signed [63:0] dy;
        logic [63:0] ux;
        logic [63:0] uy;
        logic [63:0] mx;
        logic [63:0] len;
        logic signed [63:0] c;
        logic signed [63:0] s;
        logic signed [63:0] p[2][2];
        logic signed [63:0] m[2][2];
        logic signed [63:0] t[2][2];
        logic signed [63:0] r[4];
        o  = '0;
        dx = 64'(it.node1_x) - 64'(it.node0_x);
        dy = 64'(it.node1_y) - 64'(it.node0_y);
        ux = dx < 0 ? -dx : dx;
        uy = dy < 0 ? -dy : dy;
        if (ux == 0 && uy == 0)
        begin
            o.degenerate = 1'b1;
            return o;
        end
        mx = ux > uy ? ux : uy;
        while (mx >= (64'd1 << 31))
        begin
            mx >>= 1; ux >>= 1; uy >>= 1;
        end
        while (mx < (64'd1 << 30))
        begin
            mx <<= 1; ux <<= 1; uy <<= 1;
        end
        len = int_sqrt(ux * ux + uy * uy);
        c = ((ux << 30) + (len >> 1)) / len;
        s = ((uy << 30) + (len >> 1)) / len;
        if (dx < 0) c = -c;
        if (dy < 0) s = -s;
        p[0][0] = c;
        p[1][1] = c;
        if (pfr_pkg::is_to_elem(it.cmd))
        begin
            p[0][1] = s;  p[1][0] = -s;
        end
        else
        begin
            p[0][1] = -s; p[1][0] = s;
        end
        m[0][0] = it.blk_00; m[0][1] = it.blk_01;
        m[1][0] = it.blk_10; m[1][1] = it.blk_11;
        r = '{default: 0};
        if (!pfr_pkg::is_block(it.cmd))
        begin
            for (int i = 0; i < 2; i++)
                r[i] = round_sat(mac2(m[0][0], p[i][0], m[0][1], p[i][1]),
                                 pfr_pkg::DATA_WIDTH);
        end
        else
        begin
            for (int i = 0; i < 2; i++)
                for (int j = 0; j < 2; j++)
                    t[i][j] = round_sat(mac2(m[0][j], p[i][0], m[1][j], p[i][1]), 64);
            for (int i = 0; i < 2; i++)
                for (int j = 0; j < 2; j++)
                    r[i*2+j] = round_sat(mac2(t[i][0], p[j][0], t[i][1], p[j][1]),
                                         pfr_pkg::DATA_WIDTH);
        end
        o.out_00 = r[0][31:0];
        o.out_01 = r[1][31:0];
        o.out_10 = r[2][31:0];
        o.out_11 = r[3][31:0];
        return o;
    endfunction

    function automatic pfr_pkg::in_t make_item(pfr_pkg::cmd_t c,
                                               pfr_pkg::data_t x0, pfr_pkg::data_t y0,
                                               pfr_pkg::data_t x1, pfr_pkg::data_t y1,
                                               pfr_pkg::data_t b0, pfr_pkg::data_t b1,
                                               pfr_pkg::data_t b2, pfr_pkg::data_t b3);
        pfr_pkg::in_t it;
        it.cmd = c;
        it.node0_x = x0; it.node0_y = y0; it.node1_x = x1; it.node1_y = y1;
        it.blk_00 = b0; it.blk_01 = b1; it.blk_10 = b2; it.blk_11 = b3;
        return it;
    endfunction

    function automatic pfr_pkg::data_t rand_data();
        case ($urandom_range(0, 5))
            0: return DMAX;
            1: return DMIN;
            2: return pfr_pkg::data_t'($urandom_range(0, 8)) - 4;
            3: return pfr_pkg::data_t'($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000;
            default: return pfr_pkg::data_t'($urandom);
        endcase
    endfunction

    function automatic int gap_len();
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(5, 30);
        if ($urandom_range(0, 2) == 0)
            return $urandom_range(1, 3);
        return 0;
    endfunction

    // leaves valid high so the next beat can follow at once
    task automatic send_item(pfr_pkg::in_t it, bit typed, pfr_pkg::out_t typed_val);
        item       <= it;
        item_valid <= 1'b1;
        @(posedge clk);
        while (!item_ready)
            @(posedge clk);
        expected_q.push_back(typed ? typed_val : rotate_item(it));
        cmd_seen[it.cmd]++;
        @(negedge clk);
    endtask

    typedef struct {
        pfr_pkg::in_t  it;
        bit            typed;
        pfr_pkg::out_t val;
    } stim_row_t;

    stim_row_t directed[$];

    task automatic build_directed();
        pfr_pkg::out_t z;
        pfr_pkg::out_t d;
        pfr_pkg::out_t v;
        z = '0;
        d = '0;
        d.degenerate = 1'b1;
        // zero length element, every command
        for (int k = 0; k < 4; k++)
            directed.push_back('{make_item(pfr_pkg::cmd_t'(k), 100, -7, 100, -7,
                                           DMAX, DMIN, 5, 6), 1, d});
        // axis aligned element: identity rotation, vector passes through
        v = '0; v.out_00 = 32'sh0001_0000; v.out_01 = -32'sh0002_0000;
        directed.push_back('{make_item(pfr_pkg::CMD_VEC_TO_ELEM, 0, 0, 32'sh0001_0000, 0,
                                       32'sh0001_0000, -32'sh0002_0000, DMAX, DMIN), 1, v});
        directed.push_back('{make_item(pfr_pkg::CMD_VEC_TO_GLOBAL, 0, 0, 32'sh0001_0000, 0,
                                       32'sh0001_0000, -32'sh0002_0000, 7, 7), 1, v});
        // extremes of the node span
        directed.push_back('{make_item(pfr_pkg::CMD_VEC_TO_ELEM, DMIN, DMIN, DMAX, DMAX,
                                       DMAX, DMAX, 0, 0), 0, z});
        directed.push_back('{make_item(pfr_pkg::CMD_VEC_TO_GLOBAL, DMAX, DMIN, DMIN, DMAX,
                                       DMIN, DMAX, 0, 0), 0, z});
        directed.push_back('{make_item(pfr_pkg::CMD_BLK_TO_ELEM, DMAX, DMAX, DMIN, DMIN,
                                       DMAX, DMIN, DMIN, DMAX), 0, z});
        directed.push_back('{make_item(pfr_pkg::CMD_BLK_TO_GLOBAL, DMIN, DMAX, DMAX, DMIN,
                                       DMAX, DMAX, DMAX, DMAX), 0, z});
        directed.push_back('{make_item(pfr_pkg::CMD_BLK_TO_ELEM, 0, 0, 1, 1,
                                       DMIN, DMIN, DMIN, DMIN), 0, z});
        directed.push_back('{make_item(pfr_pkg::CMD_BLK_TO_GLOBAL, 0, 0, -1, 1,
                                       DMAX, DMIN, DMAX, DMIN), 0, z});
        // tiny and lopsided spans
        directed.push_back('{make_item(pfr_pkg::CMD_VEC_TO_ELEM, 0, 0, 1, 0,
                                       -1, -1, 0, 0), 0, z});
        directed.push_back('{make_item(pfr_pkg::CMD_VEC_TO_GLOBAL, 5, 5, 5, 6,
                                       3, -3, 0, 0), 0, z});
        directed.push_back('{make_item(pfr_pkg::CMD_BLK_TO_ELEM, 0, 0, DMAX, 1,
                                       32'sh0001_0000, 2, 3, 32'sh0001_0000), 0, z});
        directed.push_back('{make_item(pfr_pkg::CMD_BLK_TO_GLOBAL, 0, 0, -3, 4,
                                       32'sh0003_0000, 32'sh0001_0000, -5, 32'sh0002_0000),
                             0, z});
    endtask

    initial
    begin
        stim_row_t row;
        pfr_pkg::in_t it;
        pfr_pkg::out_t z;
        int gap;
        item_valid = 1'b0;
        item       = '0;
        rst_n      = 1'b0;
        stim_done  = 1'b0;
        z          = '0;
        for (int k = 0; k < 4; k++)
            cmd_seen[k] = 0;
        build_directed();
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        foreach (directed[k])
        begin
            row = directed[k];
            send_item(row.it, row.typed, row.val);
        end
        for (int n = 0; n < N_RANDOM; n++)
        begin
            it.cmd = pfr_pkg::cmd_t'($urandom_range(0, 3));
            it.node0_x = rand_data(); it.node0_y = rand_data();
            if ($urandom_range(0, 15) == 0)
            begin
                it.node1_x = it.node0_x; it.node1_y = it.node0_y;
            end
            else
            begin
                it.node1_x = rand_data(); it.node1_y = rand_data();
            end
            it.blk_00 = rand_data(); it.blk_01 = rand_data();
            it.blk_10 = rand_data(); it.blk_11 = rand_data();
            // keep valid up across back-to-back beats some of the time
            gap = gap_len();
            if (gap > 0)
            begin
                item_valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            send_item(it, 1'b0, z);
        end
        item_valid <= 1'b0;
        stim_done = 1'b1;
    end

    // receiver: random stalls, plus one long hold-off to fill the pipe
    initial
    begin
        int stall;
        result_ready = 1'b0;
        hold_off     = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (!hold_off && cmd_seen[0] + cmd_seen[1] + cmd_seen[2] + cmd_seen[3] >= 150)
            begin
                hold_off = 1'b1;
                result_ready <= 1'b0;
                repeat (400) @(negedge clk);
            end
            stall = gap_len();
            if (stall > 0)
            begin
                result_ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            result_ready <= 1'b1;
        end
    end

    initial
    begin
        pfr_pkg::out_t exp_r;
        n_mismatch = 0;
        n_results  = 0;
        n_degen    = 0;
        n_sat      = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && result_valid && result_ready)
            begin
                n_results++;
                if (expected_q.size() == 0)
                begin
                    n_mismatch++;
                    if (n_mismatch <= MAX_ERR_SHOWN)
                        $display("unexpected result beat %h", result);
                end
                else
                begin
                    exp_r = expected_q.pop_front();
                    if (exp_r.degenerate)
                        n_degen++;
                    if (exp_r.out_00 == DMAX || exp_r.out_00 == DMIN)
                        n_sat++;
                    if (result !== exp_r)
                    begin
                        n_mismatch++;
                        if (n_mismatch <= MAX_ERR_SHOWN)
                            $display("mismatch beat %0d: exp %h %h %h %h d%b got %h %h %h %h d%b",
                                     n_results, exp_r.out_00, exp_r.out_01, exp_r.out_10,
                                     exp_r.out_11, exp_r.degenerate, result.out_00,
                                     result.out_01, result.out_10, result.out_11,
                                     result.degenerate);
                    end
                end
            end
        end
    end

    initial
    begin
        wait (stim_done);
        while (expected_q.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
        $display("checked %0d results: cmds %0d/%0d/%0d/%0d, %0d zero-length, %0d saturated",
                 n_results, cmd_seen[0], cmd_seen[1], cmd_seen[2], cmd_seen[3],
                 n_degen, n_sat);
        if (n_mismatch == 0 && expected_q.size() == 0)
            $display("*** PASSED ***");
        else
        begin
            $display("%0d mismatches, %0d results missing", n_mismatch, expected_q.size());
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/pfr_pkg.sv
rtl/pfr_front.sv
rtl/pfr_fifo.sv
rtl/pfr_coef.sv
rtl/pfr_dot2.sv
rtl/pfr_rotate.sv
rtl/planar_frame_rotation.sv
sim/planar_frame_rotation_tb.sv
